// ----- sv/nq_pkg.sv -----
// Shared types and constants for the N-queens first-solution search.
// No dependencies; used by nq_col_mem, nq_search and n_queens_first_solution.
`default_nettype none
package nq_pkg;

  localparam int ROWS = 16;
  localparam int IDX_W = 4;
  localparam int SIZE_W = 5;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] queen_column;
    logic             found;
    logic             last;
  } res_t;

endpackage
`default_nettype wire

// ----- sv/nq_col_mem.sv -----
// Row stack: one queen column per row, synchronous write and registered read.
// Depends on nq_pkg for the request type.
`default_nettype none
module nq_col_mem (
  input  wire logic                     clk,
  input  wire nq_pkg::mem_req_t         req,
  output logic [nq_pkg::IDX_W-1:0]      rdata
);

  logic [nq_pkg::IDX_W-1:0] mem [nq_pkg::ROWS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule
`default_nettype wire

// ----- sv/nq_search.sv -----
// Backtracking sequencer: walks rows and candidate columns, checks safety one
// stored row per cycle through the row stack, then reads the stack out.
// Depends on nq_pkg; drives nq_col_mem.
`default_nettype none
module nq_search #(
  parameter int SIZE_LIMIT = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [nq_pkg::SIZE_W-1:0] size_in,
  input  wire logic                      out_free,
  input  wire logic [nq_pkg::IDX_W-1:0]  rdata,
  output logic                           busy,
  output nq_pkg::mem_req_t               mem_req,
  output logic                           res_load,
  output nq_pkg::res_t                   res
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_TRY     = 3'd1;
  localparam logic [2:0] S_CHECK   = 3'd2;
  localparam logic [2:0] S_BACK    = 3'd3;
  localparam logic [2:0] S_EMIT_RD = 3'd4;
  localparam logic [2:0] S_EMIT_LD = 3'd5;
  localparam logic [2:0] S_NONE    = 3'd6;

  logic [2:0]                 state, state_next;
  logic [nq_pkg::SIZE_W-1:0]  size, size_next;
  logic [nq_pkg::SIZE_W-1:0]  row, row_next;
  logic [nq_pkg::SIZE_W-1:0]  col, col_next;
  logic [nq_pkg::IDX_W-1:0]   chk, chk_next;
  logic [nq_pkg::IDX_W-1:0]   k, k_next;

  logic [nq_pkg::IDX_W-1:0]   col4, diff, row_gap;
  logic                       conflict, k_last;

  assign col4 = col[nq_pkg::IDX_W-1:0];
  assign diff = (rdata >= col4) ? (rdata - col4) : (col4 - rdata);
  assign row_gap = row[nq_pkg::IDX_W-1:0] - chk;
  assign conflict = (rdata == col4) || (diff == row_gap);
  assign k_last = ({1'b0, k} + nq_pkg::SIZE_W'(1)) == size;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    size_next  = size;
    row_next   = row;
    col_next   = col;
    chk_next   = chk;
    k_next     = k;
    mem_req    = '0;
    res_load   = 1'b0;
    res        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          size_next = size_in;
          row_next  = '0;
          col_next  = '0;
          if (size_in == '0 || size_in > nq_pkg::SIZE_W'(SIZE_LIMIT)) begin
            state_next = S_NONE;
          end else begin
            state_next = S_TRY;
          end
        end
      end
      S_TRY: begin
        if (row >= size) begin
          k_next     = '0;
          state_next = S_EMIT_RD;
        end else if (col >= size) begin
          if (row == '0) begin
            col_next   = '0;
            state_next = S_NONE;
          end else begin
            // Pop one row and resume after the column it held.
            row_next      = row - nq_pkg::SIZE_W'(1);
            mem_req.re    = 1'b1;
            mem_req.raddr = row_next[nq_pkg::IDX_W-1:0];
            state_next    = S_BACK;
          end
        end else if (row == '0) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = '0;
          mem_req.wdata = col4;
          row_next      = row + nq_pkg::SIZE_W'(1);
          col_next      = '0;
        end else begin
          chk_next      = '0;
          mem_req.re    = 1'b1;
          mem_req.raddr = '0;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        // rdata holds the column of row chk; unless it conflicts or is the last row, the read of chk+1 goes out now.
        if (conflict) begin
          col_next   = col + nq_pkg::SIZE_W'(1);
          state_next = S_TRY;
        end else if ({1'b0, chk} + nq_pkg::SIZE_W'(1) == row) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = row[nq_pkg::IDX_W-1:0];
          mem_req.wdata = col4;
          row_next      = row + nq_pkg::SIZE_W'(1);
          col_next      = '0;
          state_next    = S_TRY;
        end else begin
          chk_next      = chk + nq_pkg::IDX_W'(1);
          mem_req.re    = 1'b1;
          mem_req.raddr = chk_next;
        end
      end
      S_BACK: begin
        col_next   = {1'b0, rdata} + nq_pkg::SIZE_W'(1);
        state_next = S_TRY;
      end
      S_EMIT_RD: begin
        if (out_free) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = k;
          state_next    = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        res_load         = 1'b1;
        res.row_index    = k;
        res.queen_column = rdata;
        res.found        = 1'b1;
        res.last         = k_last;
        k_next           = k + nq_pkg::IDX_W'(1);
        state_next       = k_last ? S_IDLE : S_EMIT_RD;
      end
      S_NONE: begin
        if (out_free) begin
          res_load   = 1'b1;
          res.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      row   <= '0;
      col   <= '0;
    end else begin
      state <= state_next;
      row   <= row_next;
      col   <= col_next;
    end
    size <= size_next;
    chk  <= chk_next;
    k    <= k_next;
  end

endmodule
`default_nettype wire

// ----- sv/n_queens_first_solution.sv -----
// N-queens first solution: one board size in, one result per row out (or one
// "not found" result). The row stack has a single read port, so a run checks
// each earlier row for a candidate column in turn and reads a popped row back
// on each backtrack; readout reads the stack once per result. One board is
// searched at a time. Reset (rst, synchronous) clears control state only.
`default_nettype none
module n_queens_first_solution #(
  parameter int MAX_SIZE = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [nq_pkg::SIZE_W-1:0]      board_size,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [nq_pkg::IDX_W-1:0]            row_index,
  output logic [nq_pkg::IDX_W-1:0]            queen_column,
  output logic                                found,
  output logic                                last
);

  localparam int SIZE_LIMIT = (MAX_SIZE < nq_pkg::ROWS) ? MAX_SIZE : nq_pkg::ROWS;

  nq_pkg::mem_req_t          mem_req;
  nq_pkg::res_t              res;
  logic [nq_pkg::IDX_W-1:0]  rdata;
  logic                      busy, res_load, out_free;

  assign in_stall = busy;
  assign out_free = !out_valid || !out_stall;

  nq_col_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  nq_search #(
    .SIZE_LIMIT (SIZE_LIMIT)
  ) u_search (
    .clk      (clk),
    .rst      (rst),
    .start    (in_valid && !busy),
    .size_in  (board_size),
    .out_free (out_free),
    .rdata    (rdata),
    .busy     (busy),
    .mem_req  (mem_req),
    .res_load (res_load),
    .res      (res)
  );

  // Output register: a result item holds here until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (res_load) begin
      row_index    <= res.row_index;
      queen_column <= res.queen_column;
      found        <= res.found;
      last         <= res.last;
    end
  end

endmodule
`default_nettype wire
